// ----- design/ccpe_pkg.sv -----
// Shared constants, register codes and payload types of the cubic curve point evaluator.
package ccpe_pkg;

  localparam int COORD_BITS      = 10;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int WFRAC           = 20;

  localparam int NUM_PTS    = 4;
  localparam int PARAM_W    = PARAM_FRAC_BITS + 1;
  localparam int TQ_W       = WFRAC + 1;
  localparam int ALIGN_L    = (WFRAC > PARAM_FRAC_BITS) ? (WFRAC - PARAM_FRAC_BITS) : 0;
  localparam int ALIGN_R    = (PARAM_FRAC_BITS > WFRAC) ? (PARAM_FRAC_BITS - WFRAC) : 0;
  localparam int WGT_W      = WFRAC + 8;
  localparam int PROD_W     = WGT_W + COORD_BITS + 1;
  localparam int ACC_W      = PROD_W + 2;
  localparam int OUT_W      = COORD_BITS + 2;

  localparam int REG_IDX_W  = 3;
  localparam int APB_ADDR_W = REG_IDX_W + 2;
  localparam int APB_DATA_W = 32;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_P0X, REG_P0Y, REG_P1X, REG_P1Y,
    REG_P2X, REG_P2Y, REG_P3X, REG_P3Y
  } reg_idx_t;

  typedef struct packed {
    logic [NUM_PTS-1:0][COORD_BITS-1:0] x;
    logic [NUM_PTS-1:0][COORD_BITS-1:0] y;
  } points_t;

  typedef struct packed {
    logic [TQ_W-1:0] tq;
    logic [TQ_W-1:0] t2;
    logic [TQ_W-1:0] t3;
  } powers_t;

  typedef struct packed {
    logic [NUM_PTS-1:0][WGT_W-1:0] w;
  } weights_t;

endpackage

// ----- design/ccpe_regs.sv -----
// Control point register file behind the APB-style configuration port.
module ccpe_regs import ccpe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output points_t               points
);

  logic [NUM_PTS-1:0][COORD_BITS-1:0] x_r;
  logic [NUM_PTS-1:0][COORD_BITS-1:0] y_r;
  reg_idx_t                           idx;
  logic [COORD_BITS-1:0]              wval;
  logic [COORD_BITS-1:0]              rval;
  logic                               wr_en;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wval   = pwdata[COORD_BITS-1:0];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_P0X: x_r[0] <= wval;
        REG_P0Y: y_r[0] <= wval;
        REG_P1X: x_r[1] <= wval;
        REG_P1Y: y_r[1] <= wval;
        REG_P2X: x_r[2] <= wval;
        REG_P2Y: y_r[2] <= wval;
        REG_P3X: x_r[3] <= wval;
        REG_P3Y: y_r[3] <= wval;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_P0X: rval = x_r[0];
      REG_P0Y: rval = y_r[0];
      REG_P1X: rval = x_r[1];
      REG_P1Y: rval = y_r[1];
      REG_P2X: rval = x_r[2];
      REG_P2Y: rval = y_r[2];
      REG_P3X: rval = x_r[3];
      REG_P3Y: rval = y_r[3];
    endcase
  end

  assign prdata   = APB_DATA_W'(rval);
  assign points.x = x_r;
  assign points.y = y_r;

endmodule

// ----- design/ccpe_powers.sv -----
// Three-stage front end: clamp and align t, then square it, then cube it.
module ccpe_powers import ccpe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic [PARAM_W-1:0] up_param,
  output logic               dn_valid,
  input  logic               dn_ready,
  output powers_t            dn_powers
);

  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << PARAM_FRAC_BITS;

  logic [2:0]                 valid_r;
  logic [2:0]                 valid_nxt;
  logic [2:0]                 adv;
  logic [TQ_W-1:0]            tq0_r;
  logic [TQ_W-1:0]            tq1_r;
  logic [TQ_W-1:0]            t2_1_r;
  powers_t                    pw_r;
  logic [PARAM_W-1:0]         t_sat;
  logic [PARAM_W+ALIGN_L-1:0] t_wide;
  logic [TQ_W-1:0]            tq_nxt;
  logic [2*TQ_W-1:0]          sq;
  logic [2*TQ_W-1:0]          cube;

  // A stage moves when it is empty or the stage after it moves.
  assign adv[2]   = !valid_r[2] || dn_ready;
  assign adv[1]   = !valid_r[1] || adv[2];
  assign adv[0]   = !valid_r[0] || adv[1];
  assign up_ready = adv[0];

  always_comb begin
    valid_nxt = valid_r;
    if (adv[0]) valid_nxt[0] = up_valid;
    if (adv[1]) valid_nxt[1] = valid_r[0];
    if (adv[2]) valid_nxt[2] = valid_r[1];
  end

  // Parameters above one clamp to one, then align to the weight fraction.
  assign t_sat  = (up_param > PARAM_ONE) ? PARAM_ONE : up_param;
  assign t_wide = (PARAM_W + ALIGN_L)'(t_sat) << ALIGN_L;
  assign tq_nxt = TQ_W'(t_wide >> ALIGN_R);

  assign sq   = (2*TQ_W)'(tq0_r) * (2*TQ_W)'(tq0_r);
  assign cube = (2*TQ_W)'(t2_1_r) * (2*TQ_W)'(tq1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && up_valid) begin
      tq0_r <= tq_nxt;
    end
    if (adv[1] && valid_r[0]) begin
      tq1_r  <= tq0_r;
      t2_1_r <= sq[WFRAC +: TQ_W];
    end
    if (adv[2] && valid_r[1]) begin
      pw_r.tq <= tq1_r;
      pw_r.t2 <= t2_1_r;
      pw_r.t3 <= cube[WFRAC +: TQ_W];
    end
  end

  assign dn_valid  = valid_r[2];
  assign dn_powers = pw_r;

endmodule

// ----- design/ccpe_weights.sv -----
// One stage that forms the four Lagrange basis weights, each held at twice its value.
module ccpe_weights import ccpe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  powers_t  up_powers,
  output logic     dn_valid,
  input  logic     dn_ready,
  output weights_t dn_weights
);

  localparam logic signed [WGT_W-1:0] TWO_ONE = WGT_W'(2) << WFRAC;
  localparam logic signed [WGT_W-1:0] K2  = WGT_W'(2);
  localparam logic signed [WGT_W-1:0] K9  = WGT_W'(9);
  localparam logic signed [WGT_W-1:0] K11 = WGT_W'(11);
  localparam logic signed [WGT_W-1:0] K18 = WGT_W'(18);
  localparam logic signed [WGT_W-1:0] K27 = WGT_W'(27);
  localparam logic signed [WGT_W-1:0] K36 = WGT_W'(36);
  localparam logic signed [WGT_W-1:0] K45 = WGT_W'(45);

  logic                    valid_r;
  logic                    valid_nxt;
  logic                    adv;
  weights_t                w_r;
  weights_t                w_nxt;
  logic signed [WGT_W-1:0] a;
  logic signed [WGT_W-1:0] b;
  logic signed [WGT_W-1:0] c;

  assign adv       = !valid_r || dn_ready;
  assign up_ready  = adv;
  assign valid_nxt = adv ? up_valid : valid_r;

  assign a = WGT_W'(up_powers.tq);
  assign b = WGT_W'(up_powers.t2);
  assign c = WGT_W'(up_powers.t3);

  always_comb begin
    w_nxt.w[0] = WGT_W'(TWO_ONE - K9 * c + K18 * b - K11 * a);
    w_nxt.w[1] = WGT_W'(K27 * c - K45 * b + K18 * a);
    w_nxt.w[2] = WGT_W'(K36 * b - K27 * c - K9 * a);
    w_nxt.w[3] = WGT_W'(K9 * c - K9 * b + K2 * a);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && up_valid) begin
      w_r <= w_nxt;
    end
  end

  assign dn_valid   = valid_r;
  assign dn_weights = w_r;

endmodule

// ----- design/ccpe_combine.sv -----
// Weighted sum of the control coordinates: products, sum, then truncation and clamp.
module ccpe_combine import ccpe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  weights_t                up_weights,
  input  points_t                 points,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic signed [OUT_W-1:0] dn_x,
  output logic signed [OUT_W-1:0] dn_y
);

  localparam logic signed [ACC_W-1:0] TRUNC_BIAS = (ACC_W'(1) <<< (WFRAC + 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] OUT_MAX    = (ACC_W'(1) <<< (OUT_W - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] OUT_MIN    = -(ACC_W'(1) <<< (OUT_W - 1));

  logic [2:0]               valid_r;
  logic [2:0]               valid_nxt;
  logic [2:0]               adv;
  logic signed [PROD_W-1:0] prod_x_r [NUM_PTS];
  logic signed [PROD_W-1:0] prod_y_r [NUM_PTS];
  logic signed [ACC_W-1:0]  acc_x_r;
  logic signed [ACC_W-1:0]  acc_y_r;
  logic signed [ACC_W-1:0]  acc_x_nxt;
  logic signed [ACC_W-1:0]  acc_y_nxt;
  logic signed [OUT_W-1:0]  out_x_r;
  logic signed [OUT_W-1:0]  out_y_r;

  // Divides by two to the WFRAC+1 toward zero, then clamps to the output range.
  function automatic logic signed [OUT_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] adj;
    logic signed [ACC_W-1:0] q;
    adj = acc[ACC_W-1] ? (acc + TRUNC_BIAS) : acc;
    q   = adj >>> (WFRAC + 1);
    if (q > OUT_MAX) begin
      q = OUT_MAX;
    end else if (q < OUT_MIN) begin
      q = OUT_MIN;
    end
    return q[OUT_W-1:0];
  endfunction

  assign adv[2]   = !valid_r[2] || dn_ready;
  assign adv[1]   = !valid_r[1] || adv[2];
  assign adv[0]   = !valid_r[0] || adv[1];
  assign up_ready = adv[0];

  always_comb begin
    valid_nxt = valid_r;
    if (adv[0]) valid_nxt[0] = up_valid;
    if (adv[1]) valid_nxt[1] = valid_r[0];
    if (adv[2]) valid_nxt[2] = valid_r[1];
  end

  always_comb begin
    acc_x_nxt = '0;
    acc_y_nxt = '0;
    for (int i = 0; i < NUM_PTS; i++) begin
      acc_x_nxt = acc_x_nxt + ACC_W'(prod_x_r[i]);
      acc_y_nxt = acc_y_nxt + ACC_W'(prod_y_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0] && up_valid) begin
      for (int i = 0; i < NUM_PTS; i++) begin
        prod_x_r[i] <= PROD_W'($signed(up_weights.w[i]))
                     * PROD_W'($signed({1'b0, points.x[i]}));
        prod_y_r[i] <= PROD_W'($signed(up_weights.w[i]))
                     * PROD_W'($signed({1'b0, points.y[i]}));
      end
    end
    if (adv[1] && valid_r[0]) begin
      acc_x_r <= acc_x_nxt;
      acc_y_r <= acc_y_nxt;
    end
    if (adv[2] && valid_r[1]) begin
      out_x_r <= finish(acc_x_r);
      out_y_r <= finish(acc_y_r);
    end
  end

  assign dn_valid = valid_r[2];
  assign dn_x     = out_x_r;
  assign dn_y     = out_y_r;

endmodule

// ----- design/cubic_curve_point_evaluator.sv -----
// Top level of the cubic curve point evaluator: configuration port and point pipeline.
//
// Usage: program the four control points through the APB-style port (psel, penable,
// pwrite, paddr, pwdata, prdata, pready); point i x and y sit at byte addresses 8*i
// and 8*i+4, and only their low ten bits are kept. pready is always high, and a
// read returns the stored value. Rewrite the points only while no request is in
// flight. Each request on the in_ channel carries a curve parameter t in unsigned
// Q1.16 (values above one act as one); the out_ channel returns the curve point
// through the four control points at t = 0, 1/3, 2/3 and 1, each coordinate
// truncated toward zero to a signed integer and clamped to twelve bits.
// A request passes through seven register stages in order (align, square, cube,
// weights, products, sum, finish), each with its own valid bit, and the squaring
// and the cubing each get a stage of their own. Throughput is one request per
// cycle while the receiver does not stall.
// When the receiver stalls, the pipeline keeps moving until its stages fill up, so
// empty slots are squeezed out; then in_ready falls and nothing is dropped or
// repeated. Synchronous reset empties the pipeline and clears all control points.
module cubic_curve_point_evaluator import ccpe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PARAM_W-1:0]      in_curve_param,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_point_x,
  output logic signed [OUT_W-1:0] out_point_y,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready
);

  points_t  points;
  powers_t  powers;
  weights_t weights;
  logic     pw_valid;
  logic     pw_ready;
  logic     wt_valid;
  logic     wt_ready;

  // Control points live here and the combine stage reads them directly. The user must
  // change them only while the pipeline is empty; the block does not enforce it.
  ccpe_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .points  (points)
  );

  // Stages one to three: clamp and align t, then t squared, then t cubed.
  ccpe_powers u_powers (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .up_param  (in_curve_param),
    .dn_valid  (pw_valid),
    .dn_ready  (pw_ready),
    .dn_powers (powers)
  );

  // Stage four: the basis weights, built from constant multiplies and adds.
  ccpe_weights u_weights (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (pw_valid),
    .up_ready   (pw_ready),
    .up_powers  (powers),
    .dn_valid   (wt_valid),
    .dn_ready   (wt_ready),
    .dn_weights (weights)
  );

  // Stages five to seven: products, their sum, and the final truncate and clamp.
  // The last stage is the output register.
  ccpe_combine u_combine (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (wt_valid),
    .up_ready   (wt_ready),
    .up_weights (weights),
    .points     (points),
    .dn_valid   (out_valid),
    .dn_ready   (out_ready),
    .dn_x       (out_point_x),
    .dn_y       (out_point_y)
  );

`ifndef SYNTH
  // With the receiver ready, every stage advances, so the block must take a request.
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("in_ready low while out_ready high");

  // An empty output register must let the whole pipeline move.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with an empty output stage");

  // Reset empties the pipeline.
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result still valid after reset");

  // A written point reads back with only its coordinate bits kept.
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite) ##1 (paddr == $past(paddr))
      |-> (prdata == APB_DATA_W'($past(pwdata[COORD_BITS-1:0]))))
    else $error("configuration read-back mismatch");
`endif

endmodule
